@@ design/sorted_priority_queue_top_assert.svh @@
// Assertion macros used by the checker file of the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Checks that a condition implies a property in the same cycle.
`define SPQ_ASSERT_SAME(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("sorted priority queue check failed");

// Checks that a condition implies a property in the following cycle.
`define SPQ_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("sorted priority queue check failed");

`endif

@@ design/spq_pkg.sv @@
// Package with sizes, codes and interface types of the sorted priority queue.
package spq_pkg;

	localparam int DEPTH        = 16;
	localparam int PRIO_BITS    = 16;
	localparam int PAYLOAD_BITS = 16;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	localparam int IN_RAW_W   = PRIO_BITS + PAYLOAD_BITS;
	localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
	localparam int OUT_RAW_W  = 2 * PAYLOAD_BITS + 1 + CNT_W;
	localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

	localparam int OUT_LEFT_LSB  = 0;
	localparam int OUT_HEAD_LSB  = PAYLOAD_BITS;
	localparam int OUT_EMPTY_BIT = 2 * PAYLOAD_BITS;
	localparam int OUT_CNT_LSB   = 2 * PAYLOAD_BITS + 1;

	typedef enum logic {
		OP_JOIN  = 1'b0,
		OP_LEAVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		RES_DONE  = 2'd0,
		RES_EMPTY = 2'd1,
		RES_FULL  = 2'd2
	} res_status_t;

	typedef enum logic {
		CS_IDLE = 1'b0,
		CS_HOLD = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic        join_en;
		logic        leave_en;
		logic        load_out;
		res_status_t status;
	} dp_cmd_t;

	typedef struct packed {
		logic is_leave;
		logic full;
		logic empty;
	} dp_stat_t;

endpackage

@@ design/spq_datapath.sv @@
// Datapath of the sorted priority queue: compare-and-shift entry array and result register.
module spq_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [spq_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           s_tuser,
	input  spq_pkg::dp_cmd_t               cmd,
	output spq_pkg::dp_stat_t              stat,
	output logic [spq_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [1:0]                     m_tuser
);
	import spq_pkg::*;

	logic [PRIO_BITS-1:0]    prio_q [DEPTH];
	logic [PAYLOAD_BITS-1:0] pay_q [DEPTH];
	logic [CNT_W-1:0]        held_q;

	logic [PRIO_BITS-1:0]    in_prio;
	logic [PAYLOAD_BITS-1:0] in_pay;
	logic                    front;
	logic [DEPTH-1:0]        hit;
	logic [DEPTH-1:0]        above;
	logic [CNT_W-1:0]        held_nx;
	logic [PAYLOAD_BITS-1:0] head_nx;
	logic [PAYLOAD_BITS-1:0] left_nx;

	logic [PAYLOAD_BITS-1:0] out_left_q;
	logic [PAYLOAD_BITS-1:0] out_head_q;
	logic                    out_empty_q;
	logic [CNT_W-1:0]        out_cnt_q;
	res_status_t             out_status_q;

	assign in_prio = s_tdata[PRIO_BITS-1:0];
	assign in_pay  = s_tdata[PRIO_BITS +: PAYLOAD_BITS];

	assign stat.is_leave = s_tuser;
	assign stat.full     = (held_q == DEPTH_CNT);
	assign stat.empty    = (held_q == '0);

	assign front = (held_q == '0) || (prio_q[0] > in_prio);

	// The new entry lands at the first position that hits; entries past it move up.
	assign hit[0] = front;
	for (genvar i = 1; i < DEPTH; i++) begin : g_hit
		assign hit[i] = !front && (((CNT_W'(i) < held_q) && (prio_q[i] >= in_prio)) ||
			(CNT_W'(i) == held_q));
	end

	always_comb begin
		above[0] = 1'b0;
		for (int i = 1; i < DEPTH; i++) begin
			above[i] = above[i-1] | hit[i-1];
		end
	end

	always_comb begin
		held_nx = held_q;
		left_nx = '0;
		if (cmd.join_en) begin
			held_nx = held_q + 1'b1;
			head_nx = front ? in_pay : pay_q[0];
		end else if (cmd.leave_en) begin
			held_nx = held_q - 1'b1;
			left_nx = pay_q[0];
			head_nx = (held_q > CNT_W'(1)) ? pay_q[1] : '0;
		end else begin
			head_nx = (held_q != '0) ? pay_q[0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else begin
			held_q <= held_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.join_en && hit[0]) begin
			prio_q[0] <= in_prio;
			pay_q[0]  <= in_pay;
		end else if (cmd.leave_en) begin
			prio_q[0] <= prio_q[1];
			pay_q[0]  <= pay_q[1];
		end
	end

	for (genvar i = 1; i < DEPTH; i++) begin : g_entry
		always_ff @(posedge clk) begin
			if (cmd.join_en) begin
				if (above[i]) begin
					prio_q[i] <= prio_q[i-1];
					pay_q[i]  <= pay_q[i-1];
				end else if (hit[i]) begin
					prio_q[i] <= in_prio;
					pay_q[i]  <= in_pay;
				end
			end else if (cmd.leave_en && (i < DEPTH - 1)) begin
				prio_q[i] <= prio_q[(i + 1) % DEPTH];
				pay_q[i]  <= pay_q[(i + 1) % DEPTH];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_left_q   <= left_nx;
			out_head_q   <= head_nx;
			out_empty_q  <= (held_nx == '0);
			out_cnt_q    <= held_nx;
			out_status_q <= cmd.status;
		end
	end

	always_comb begin
		m_tdata = '0;
		m_tdata[OUT_LEFT_LSB +: PAYLOAD_BITS] = out_left_q;
		m_tdata[OUT_HEAD_LSB +: PAYLOAD_BITS] = out_head_q;
		m_tdata[OUT_EMPTY_BIT]                = out_empty_q;
		m_tdata[OUT_CNT_LSB +: CNT_W]         = out_cnt_q;
	end

	assign m_tuser = out_status_q;

endmodule

@@ design/spq_controller.sv @@
// Controller of the sorted priority queue: request handshake and result register state.
module spq_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  spq_pkg::dp_stat_t stat,
	output spq_pkg::dp_cmd_t  cmd
);
	import spq_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nx;
	logic        accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx     = state_q;
		s_tready     = 1'b1;
		m_tvalid     = 1'b0;
		case (state_q)
			CS_IDLE: begin
				s_tready = 1'b1;
				m_tvalid = 1'b0;
			end
			CS_HOLD: begin
				s_tready = m_tready;
				m_tvalid = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
				m_tvalid = 1'b0;
			end
		endcase
		accept = s_tvalid && s_tready;
		if (accept) begin
			state_nx = CS_HOLD;
		end else if (m_tready || (state_q != CS_HOLD)) begin
			state_nx = CS_IDLE;
		end

		cmd.load_out = accept;
		cmd.join_en  = accept && (stat.is_leave == OP_JOIN) && !stat.full;
		cmd.leave_en = accept && (stat.is_leave == OP_LEAVE) && !stat.empty;
		if (stat.is_leave == OP_LEAVE) begin
			cmd.status = stat.empty ? RES_EMPTY : RES_DONE;
		end else begin
			cmd.status = stat.full ? RES_FULL : RES_DONE;
		end
	end

endmodule

@@ design/sorted_priority_queue_top.sv @@
// Latency: a request's result is shown in the cycle after the request is accepted.
// Throughput: one request per cycle while the output is not stalled by m_tready; each join
// or leave that is carried out updates the whole compare-and-shift entry array together, and
// the result register is refilled in the cycle it is taken. Reset clears the entry count and the
// result valid state at once; the entry array itself is not cleared.
module sorted_priority_queue_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [spq_pkg::IN_DATA_W-1:0]  s_tdata,  // prio, payload
	input  logic                           s_tuser,  // op
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [spq_pkg::OUT_DATA_W-1:0] m_tdata,  // left_payload, head_payload, is_empty, count
	output logic [1:0]                     m_tuser   // status
);
	import spq_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	spq_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	spq_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.cmd     (cmd),
		.stat    (stat),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

@@ design/spq_checker.sv @@
// Port-level checker of the sorted priority queue and its bind to the top level.
`include "sorted_priority_queue_top_assert.svh"

module spq_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [spq_pkg::IN_DATA_W-1:0]  s_tdata,
	input logic                           s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [spq_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [1:0]                     m_tuser
);
	import spq_pkg::*;

	logic [PAYLOAD_BITS-1:0] left_f;
	logic [PAYLOAD_BITS-1:0] head_f;
	logic                    empty_f;
	logic [CNT_W-1:0]        cnt_f;

	assign left_f  = m_tdata[OUT_LEFT_LSB +: PAYLOAD_BITS];
	assign head_f  = m_tdata[OUT_HEAD_LSB +: PAYLOAD_BITS];
	assign empty_f = m_tdata[OUT_EMPTY_BIT];
	assign cnt_f   = m_tdata[OUT_CNT_LSB +: CNT_W];

	`SPQ_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`SPQ_ASSERT_SAME(a_ready_when_free, !m_tvalid, s_tready)
	`SPQ_ASSERT_SAME(a_count_range, m_tvalid, (cnt_f <= DEPTH_CNT) && (empty_f == (cnt_f == '0)))
	`SPQ_ASSERT_SAME(a_empty_head, m_tvalid && empty_f, head_f == '0)
	`SPQ_ASSERT_NEXT(a_join_left, s_tvalid && s_tready && (s_tuser == OP_JOIN), m_tvalid && (left_f == '0))

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (.*);

@@ sim/tb_sorted_priority_queue_top.sv @@
// Self-checking testbench for the sorted min-priority queue stream block.
module tb_sorted_priority_queue_top;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	typedef struct {
		res_status_t       status;
		logic [15:0]       left_pl;
		logic [15:0]       head_pl;
		logic              empty;
		logic [CNT_W-1:0]  count;
	} spq_res_t;

	typedef struct {
		op_t         op;
		logic [15:0] prio;
		logic [15:0] pl;
		bit          typed;
		spq_res_t    res;
	} stim_row_t;

	localparam int N_DIR     = 21;
	localparam int N_BLOCKS  = 40;
	localparam int BLOCK_LEN = 50;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;

	logic [15:0] prio_q [DEPTH];
	logic [15:0] pl_q [DEPTH];
	int          held_cnt = 0;

	spq_res_t  pending_results [$];
	int        mismatches = 0;
	int        results_seen = 0;
	int        tx_calm = 0;
	int        rx_calm = 0;
	stim_row_t dir_tab [N_DIR];

	sorted_priority_queue_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm = $urandom_range(10, 40);
		end
		return $urandom_range(0, 13);
	endfunction

	function automatic spq_res_t queue_apply(op_t op, logic [15:0] pr, logic [15:0] pl);
		spq_res_t r;
		int pos;
		r.status  = RES_DONE;
		r.left_pl = '0;
		if (op == OP_JOIN) begin
			if (held_cnt >= DEPTH) begin
				r.status = RES_FULL;
			end else begin
				if (held_cnt == 0 || prio_q[0] > pr) begin
					pos = 0;
				end else begin
					pos = 1;
					while (pos < held_cnt && prio_q[pos] < pr) pos++;
				end
				for (int i = held_cnt; i > pos; i--) begin
					prio_q[i] = prio_q[i-1];
					pl_q[i]   = pl_q[i-1];
				end
				prio_q[pos] = pr;
				pl_q[pos]   = pl;
				held_cnt++;
			end
		end else begin
			if (held_cnt == 0) begin
				r.status = RES_EMPTY;
			end else begin
				r.left_pl = pl_q[0];
				for (int i = 1; i < held_cnt; i++) begin
					prio_q[i-1] = prio_q[i];
					pl_q[i-1]   = pl_q[i];
				end
				held_cnt--;
			end
		end
		r.head_pl = (held_cnt > 0) ? pl_q[0] : 16'h0000;
		r.empty   = (held_cnt == 0);
		r.count   = CNT_W'(held_cnt);
		return r;
	endfunction

	task automatic send_req(input op_t op, input logic [15:0] pr, input logic [15:0] pl,
			input bit typed, input spq_res_t typed_res);
		int gap;
		spq_res_t r;
		gap = draw_gap(tx_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= IN_DATA_W'({pl, pr});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = queue_apply(op, pr, pl);
		pending_results.push_back(typed ? typed_res : r);
	endtask

	task automatic check_result(input logic [OUT_DATA_W-1:0] d, input logic [1:0] u);
		spq_res_t got;
		spq_res_t want;
		got.status  = res_status_t'(u);
		got.left_pl = d[OUT_LEFT_LSB +: PAYLOAD_BITS];
		got.head_pl = d[OUT_HEAD_LSB +: PAYLOAD_BITS];
		got.empty   = d[OUT_EMPTY_BIT];
		got.count   = d[OUT_CNT_LSB +: CNT_W];
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("Unexpected result: status=%0d left=%h head=%h empty=%0d count=%0d",
					got.status, got.left_pl, got.head_pl, got.empty, got.count);
			end
			return;
		end
		want = pending_results.pop_front();
		if (got.status !== want.status || got.left_pl !== want.left_pl ||
				got.head_pl !== want.head_pl || got.empty !== want.empty ||
				got.count !== want.count) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("Mismatch at result %0d: expected status=%0d left=%h head=%h empty=%0d count=%0d",
					results_seen, want.status, want.left_pl, want.head_pl, want.empty, want.count);
				$display("  actual status=%0d left=%h head=%h empty=%0d count=%0d",
					got.status, got.left_pl, got.head_pl, got.empty, got.count);
			end
		end
	endtask

	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			if (results_seen == 400) begin
				gap = 120;
			end else begin
				gap = draw_gap(rx_calm);
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			check_result(m_tdata, m_tuser);
			results_seen++;
		end
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		spq_res_t none;
		int join_pct;
		int prio_mode;
		op_t op;
		logic [15:0] pr;
		none = '{RES_DONE, 16'h0, 16'h0, 1'b0, '0};
		dir_tab = '{
			'{OP_LEAVE, 16'h0000, 16'h0000, 1, '{RES_EMPTY, 16'h0, 16'h0, 1'b1, CNT_W'(0)}},
			'{OP_JOIN, 16'h8000, 16'h1111, 1, '{RES_DONE, 16'h0, 16'h1111, 1'b0, CNT_W'(1)}},
			'{OP_JOIN, 16'hFFFF, 16'hFFFF, 0, none},
			'{OP_JOIN, 16'h0000, 16'h0000, 1, '{RES_DONE, 16'h0, 16'h0000, 1'b0, CNT_W'(3)}},
			'{OP_JOIN, 16'h0000, 16'hAAAA, 0, none},
			'{OP_JOIN, 16'h8000, 16'h5555, 0, none},
			'{OP_JOIN, 16'hFFFF, 16'h0001, 0, none},
			'{OP_JOIN, 16'h0001, 16'h8000, 0, none},
			'{OP_JOIN, 16'h7FFF, 16'h7FFF, 0, none},
			'{OP_JOIN, 16'hFFFE, 16'h4321, 0, none},
			'{OP_JOIN, 16'h0002, 16'h1234, 0, none},
			'{OP_JOIN, 16'h8000, 16'h0F0F, 0, none},
			'{OP_JOIN, 16'h1000, 16'hF0F0, 0, none},
			'{OP_JOIN, 16'h0000, 16'h00FF, 0, none},
			'{OP_JOIN, 16'hC000, 16'hFF00, 0, none},
			'{OP_JOIN, 16'h4000, 16'h3C3C, 0, none},
			'{OP_JOIN, 16'h2000, 16'hC3C3, 0, none},
			'{OP_JOIN, 16'h0000, 16'hDEAD, 1, '{RES_FULL, 16'h0, 16'h0000, 1'b0, CNT_W'(16)}},
			'{OP_LEAVE, 16'hFFFF, 16'hFFFF, 0, none},
			'{OP_LEAVE, 16'h5A5A, 16'hA5A5, 0, none},
			'{OP_LEAVE, 16'h0000, 16'h0000, 0, none}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < N_DIR; n++) begin
			send_req(dir_tab[n].op, dir_tab[n].prio, dir_tab[n].pl, dir_tab[n].typed,
				dir_tab[n].res);
		end

		for (int b = 0; b < N_BLOCKS; b++) begin
			if (b == N_BLOCKS / 2) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0) @(posedge clk);
			end
			join_pct  = $urandom_range(15, 85);
			prio_mode = $urandom_range(0, 2);
			for (int k = 0; k < BLOCK_LEN; k++) begin
				op = ($urandom_range(0, 99) < join_pct) ? OP_JOIN : OP_LEAVE;
				case (prio_mode)
					0: pr = 16'($urandom_range(0, 65535));
					1: pr = 16'($urandom_range(0, 7));
					default: begin
						case ($urandom_range(0, 3))
							0: pr = 16'h0000;
							1: pr = 16'hFFFF;
							2: pr = 16'h7FFF;
							default: pr = 16'h8000;
						endcase
					end
				endcase
				send_req(op, pr, 16'($urandom_range(0, 65535)), 0, none);
			end
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
